// ===== rtl/core/mlgm_pkg.sv =====
// mlgm_pkg: shared types and constants of the midi learn gate mapper
// beat structs, scan token, register and state codes; no dependencies
`timescale 1ns / 1ps

package mlgm_pkg;

  localparam int unsigned MAX_GATES = 16;
  localparam int unsigned IDX_W     = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int unsigned PTR_W     = $clog2(MAX_GATES + 1);

  typedef struct packed {
    logic       action;
    logic [4:0] midi_channel;
    logic [6:0] note_pitch;
  } in_beat_t;

  typedef struct packed {
    logic       gate_fire;
    logic [3:0] gate_index;
    logic       led_fire;
    logic       learning;
    logic [4:0] learn_position;
  } out_beat_t;

  typedef struct packed {
    logic [6:0] note;
    logic [4:0] chan;
  } entry_t;

  typedef struct packed {
    logic             live;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [6:0]       note;
    logic [4:0]       chan;
  } scan_tok_t;

  typedef enum logic [0:0] {
    CFG_GATE_COUNT   = 1'b0,
    CFG_LED_SUPPRESS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  localparam logic [0:0] ACT_NOTE_ON = 1'b0;

endpackage

// ===== rtl/core/mlgm_cell.sv =====
// mlgm_cell: one gate entry of the chain plus one stage of the match scan
// depends on mlgm_pkg
`timescale 1ns / 1ps

module mlgm_cell
  import mlgm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  logic             in_range_i,
  input  logic             wr_en_i,
  input  entry_t           wr_entry_i,
  input  scan_tok_t        tok_i,
  output scan_tok_t        tok_o
);

  entry_t    entry_q;
  entry_t    entry_d;
  scan_tok_t tok_q;
  scan_tok_t tok_d;
  logic      match;

  assign entry_d = wr_en_i ? wr_entry_i : entry_q;

  assign match = tok_i.live && !tok_i.hit && in_range_i && (entry_q.chan != 5'd0) &&
                 (entry_q.note == tok_i.note) && (entry_q.chan == tok_i.chan);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit = 1'b1;
      tok_d.idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      tok_q   <= '0;
    end else begin
      entry_q <= entry_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/core/midi_learn_gate_mapper_unit.sv =====
// midi_learn_gate_mapper_unit: midi learn note to gate map, top level
// learn and start beats go straight to the output register; note-on match beats first walk the scan chain
// one beat in flight: a new beat is taken only once the last result has been taken at the output
// match time is set by the token walking the chain of MAX_GATES cells, one per cycle
// reset clears the whole table, learning, pointer, gate count 8, led suppress 0
// depends on mlgm_pkg and mlgm_cell
`timescale 1ns / 1ps

module midi_learn_gate_mapper_unit
  import mlgm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_beat_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_beat_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [4:0] cfg_wdata_i
);

  state_e     state_q, state_d;
  logic [4:0] gate_count_q, gate_count_d;
  logic       led_suppress_q, led_suppress_d;
  logic       learn_q, learn_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_q, out_d;

  logic [PTR_W-1:0] count;
  logic             accept;
  logic             learn_wr;
  entry_t           wr_entry;
  scan_tok_t        tok_start;
  scan_tok_t        tok [MAX_GATES+1];
  logic [31:0]      pos_w;
  logic [31:0]      idx_w;

  assign count = (32'(gate_count_q) > 32'(MAX_GATES)) ? PTR_W'(MAX_GATES)
                                                      : PTR_W'(gate_count_q);

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  assign learn_wr = accept && (in_data_i.action == ACT_NOTE_ON) && learn_q &&
                    (32'(ptr_q) < 32'(MAX_GATES));
  assign wr_entry = '{note: in_data_i.note_pitch, chan: in_data_i.midi_channel};

  always_comb begin
    tok_start      = '0;
    tok_start.live = accept && (in_data_i.action == ACT_NOTE_ON) && !learn_q;
    tok_start.note = in_data_i.note_pitch;
    tok_start.chan = in_data_i.midi_channel;
  end

  assign tok[0] = tok_start;

  for (genvar g = 0; g < MAX_GATES; g++) begin : g_cell
    mlgm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .in_range_i (32'(g) < 32'(count)),
      .wr_en_i    (learn_wr && (ptr_q == PTR_W'(g))),
      .wr_entry_i (wr_entry),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
  end

  always_comb begin
    gate_count_d   = gate_count_q;
    led_suppress_d = led_suppress_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GATE_COUNT:   gate_count_d   = cfg_wdata_i;
        CFG_LED_SUPPRESS: led_suppress_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    learn_d     = learn_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pos_w       = 32'(ptr_q);
    idx_w       = 32'(tok[MAX_GATES].idx);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.action != ACT_NOTE_ON) begin
            learn_d = 1'b1;
            ptr_d   = '0;
          end else if (learn_q) begin
            if (32'(ptr_q) < 32'(MAX_GATES)) begin
              ptr_d = ptr_q + PTR_W'(1);
            end
            if ((ptr_d >= count) || (32'(ptr_d) >= 32'(MAX_GATES))) begin
              learn_d = 1'b0;
            end
          end
          if ((in_data_i.action != ACT_NOTE_ON) || learn_q) begin
            pos_w       = 32'(ptr_d);
            out_d       = '{gate_fire: 1'b0, gate_index: 4'd0, led_fire: 1'b0,
                            learning: learn_d, learn_position: pos_w[4:0]};
            out_valid_d = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tok[MAX_GATES].live) begin
          out_d.gate_fire      = tok[MAX_GATES].hit;
          out_d.gate_index     = tok[MAX_GATES].hit ? idx_w[3:0] : 4'd0;
          out_d.led_fire       = tok[MAX_GATES].hit && !led_suppress_q;
          out_d.learning       = learn_q;
          out_d.learn_position = pos_w[4:0];
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      gate_count_q   <= 5'd8;
      led_suppress_q <= 1'b0;
      learn_q        <= 1'b0;
      ptr_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      gate_count_q   <= gate_count_d;
      led_suppress_q <= led_suppress_d;
      learn_q        <= learn_d;
      ptr_q          <= ptr_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/mlgm_checker.sv =====
// mlgm_checker: port level assertions for midi_learn_gate_mapper_unit
// depends on mlgm_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module mlgm_checker
  import mlgm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input out_beat_t  out_data_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // no fire means zero index and no led
  a_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.gate_fire |-> out_data_o.gate_index == 4'd0 &&
    !out_data_o.led_fire)
    else $error("index or led set without gate fire");

  // no gate fires on a beat that leaves learning on
  a_learn_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.learning |-> !out_data_o.gate_fire)
    else $error("gate fired while learning");

  // one beat in flight at a time
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while one is in flight");

endmodule

bind midi_learn_gate_mapper_unit mlgm_checker u_mlgm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
